FILE: rtl/cct_pkg.sv
// shared types, codes and constants of the compare/capture timer
// no dependencies; imported by cct_timer and compare_capture_timer_core
`default_nettype none

package cct_pkg;

   // item kinds carried on the request tuser
   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_TIN   = 2'd3
   } kind_type;

   // register map
   localparam logic [2:0] REG_CTRL     = 3'd0;
   localparam logic [2:0] REG_PRESCALE = 3'd1;
   localparam logic [2:0] REG_COMPARE  = 3'd2;
   localparam logic [2:0] REG_CAPTURE  = 3'd3;
   localparam logic [2:0] REG_COUNT    = 3'd4;
   localparam logic [2:0] REG_STATUS   = 3'd5;

   // control register bit positions
   localparam int CTL_EN      = 0;
   localparam int CTL_SRC_LO  = 1;
   localparam int CTL_COMPEN  = 4;
   localparam int CTL_CAPTEN  = 5;
   localparam int CTL_MODE_LO = 6;
   localparam int CTL_FREERUN = 8;
   localparam int CTL_SOFTRST = 15;

   // clock source codes
   localparam logic [2:0] SRC_TICK     = 3'd1;
   localparam logic [2:0] SRC_TICK_DIV = 3'd2;

   // capture mode codes
   localparam logic [1:0] CAP_RISE = 2'd1;
   localparam logic [1:0] CAP_FALL = 2'd2;
   localparam logic [1:0] CAP_ANY  = 2'd3;

   // status bit positions
   localparam int ST_COMP = 0;
   localparam int ST_CAPT = 1;

   localparam int PRESCALE_W = 11;
   localparam int DIV_W      = 16;
   localparam logic [DIV_W-1:0] SLOW_CLOCK_DIVIDER = 16'd1464;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  reg_index;
      logic [31:0] write_data;
      logic        tin_level;
   } item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_n;
      logic        compare_hit;
   } result_type;

   typedef struct packed {
      logic enable;
      logic count_zero;
   } timer_status_type;

endpackage

`default_nettype wire

FILE: rtl/cct_timer.sv
// timer register file and the single-pass update for one item
// depends on cct_pkg
`default_nettype none

module cct_timer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire cct_pkg::item_type         item,
   output cct_pkg::result_type            result,
   output cct_pkg::timer_status_type      status
);
   import cct_pkg::*;

   logic [31:0]           ctrl_ff, ctrl_in;
   logic [PRESCALE_W-1:0] prescale_ff, prescale_in;
   logic [31:0]           compare_ff, compare_in;
   logic [31:0]           capture_ff, capture_in;
   logic [31:0]           count_ff, count_in;
   logic [1:0]            status_ff, status_in;
   logic [DIV_W-1:0]      psc_cnt_ff, psc_cnt_in;

   logic [2:0]            src;
   logic [1:0]            cap_mode;
   logic [PRESCALE_W:0]   period;
   logic [DIV_W-1:0]      divider;
   logic [DIV_W:0]        psc_next;
   logic [31:0]           count_inc;
   logic                  take;
   logic                  hit;
   logic [31:0]           rd;

   assign src      = ctrl_ff[CTL_SRC_LO +: 3];
   assign cap_mode = ctrl_ff[CTL_MODE_LO +: 2];
   assign period   = {1'b0, prescale_ff} + {{PRESCALE_W{1'b0}}, 1'b1};
   assign psc_next = {1'b0, psc_cnt_ff} + {{DIV_W{1'b0}}, 1'b1};
   assign count_inc = count_ff + 32'd1;

   always_comb begin
      priority if (src == SRC_TICK) begin
         divider = DIV_W'({period, 1'b0});
      end else if (src == SRC_TICK_DIV) begin
         divider = DIV_W'({period, 3'b000});
      end else if (src[2]) begin
         divider = SLOW_CLOCK_DIVIDER;
      end else begin
         divider = '0;
      end
   end

   assign take = (cap_mode == CAP_ANY) ||
                 ((cap_mode == CAP_RISE) && item.tin_level) ||
                 ((cap_mode == CAP_FALL) && !item.tin_level);

   always_comb begin
      ctrl_in     = ctrl_ff;
      prescale_in = prescale_ff;
      compare_in  = compare_ff;
      capture_in  = capture_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      psc_cnt_in  = psc_cnt_ff;
      hit         = 1'b0;
      rd          = '0;
      unique case (item.kind)
         KIND_TICK: begin
            if (!ctrl_ff[CTL_EN]) begin
               count_in = '0;
            end else if (divider != '0) begin
               if (psc_next < {1'b0, divider}) begin
                  psc_cnt_in = psc_next[DIV_W-1:0];
               end else begin
                  psc_cnt_in = '0;
                  count_in   = count_inc;
                  // zero compare never matches; the wrap to zero is not a hit
                  if (count_inc == compare_ff && compare_ff != '0) begin
                     status_in[ST_COMP] = 1'b1;
                     hit                = 1'b1;
                     if (!ctrl_ff[CTL_FREERUN]) begin
                        count_in = '0;
                     end
                  end
               end
            end
         end
         KIND_READ: begin
            unique case (item.reg_index)
               REG_CTRL:     rd = ctrl_ff;
               REG_PRESCALE: rd = {{(32-PRESCALE_W){1'b0}}, prescale_ff};
               REG_COMPARE:  rd = compare_ff;
               REG_CAPTURE:  rd = capture_ff;
               REG_COUNT:    rd = count_ff;
               REG_STATUS:   rd = {30'd0, status_ff};
               default:      rd = '0;
            endcase
         end
         KIND_WRITE: begin
            unique case (item.reg_index)
               REG_CTRL: begin
                  if (item.write_data[CTL_SOFTRST]) begin
                     // soft reset keeps only the enable bit
                     ctrl_in     = {31'd0, ctrl_ff[CTL_EN]};
                     prescale_in = '0;
                     compare_in  = '1;
                     capture_in  = '0;
                     count_in    = '0;
                     status_in   = '0;
                     psc_cnt_in  = '0;
                  end else begin
                     ctrl_in = item.write_data;
                     if (!item.write_data[CTL_EN]) begin
                        count_in = '0;
                     end
                  end
               end
               REG_PRESCALE: prescale_in = item.write_data[PRESCALE_W-1:0];
               REG_COMPARE:  compare_in  = item.write_data;
               REG_STATUS:   status_in   = status_ff & ~item.write_data[1:0];
               default: ;
            endcase
         end
         KIND_TIN: begin
            if (take) begin
               capture_in          = ctrl_ff[CTL_EN] ? count_ff : 32'd0;
               status_in[ST_CAPT]  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // interrupt follows the state left behind by this transaction
   assign result.read_data   = rd;
   assign result.compare_hit = hit;
   assign result.irq_n = !((ctrl_in[CTL_COMPEN] && status_in[ST_COMP]) ||
                           (ctrl_in[CTL_CAPTEN] && status_in[ST_CAPT]));

   assign status.enable     = ctrl_ff[CTL_EN];
   assign status.count_zero = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff     <= '0;
         prescale_ff <= '0;
         compare_ff  <= '1;
         capture_ff  <= '0;
         count_ff    <= '0;
         status_ff   <= '0;
         psc_cnt_ff  <= '0;
      end else if (advance) begin
         ctrl_ff     <= ctrl_in;
         prescale_ff <= prescale_in;
         compare_ff  <= compare_in;
         capture_ff  <= capture_in;
         count_ff    <= count_in;
         status_ff   <= status_in;
         psc_cnt_ff  <= psc_cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/compare_capture_timer_core.sv
// top level of the compare/capture timer: request register, result register
// depends on cct_pkg and cct_timer
`default_nettype none

// The timer takes one transaction per clock (tick, register read, register
// write or TIN level change) while the response side does not stall, and
// returns exactly one response per transaction, in order. Each request is
// held in the request register, passes the single update pass, and its
// response is held in the response register. Stalls on the response side
// back up through the request register without losing data.
module compare_capture_timer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // reg_index[2:0], write_data[34:3], tin_level[35], zero
   input  wire logic [1:0]  req_tuser,  // kind[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata   // read_data[31:0], irq_n[32], compare_hit[33], zero
);
   import cct_pkg::*;

   item_type         item_ff, item_in;
   logic             item_valid_ff;
   result_type       rsp_ff, result;
   logic             rsp_valid_ff;
   timer_status_type tstat;
   logic             out_free;
   logic             advance;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = item_valid_ff && out_free;
   assign req_tready = !item_valid_ff || advance;

   assign item_in.kind       = kind_type'(req_tuser);
   assign item_in.reg_index  = req_tdata[2:0];
   assign item_in.write_data = req_tdata[34:3];
   assign item_in.tin_level  = req_tdata[35];

   cct_timer u_timer (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .result  (result),
      .status  (tstat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_tready) begin
            item_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= item_valid_ff;
         end
      end
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.compare_hit, rsp_ff.irq_n, rsp_ff.read_data};

`ifndef SYNTHESIS
   a_hit_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      advance && result.compare_hit |-> item_ff.kind == KIND_TICK)
      else $error("compare hit from a non-tick transaction");

   a_read_data_zero: assert property (@(posedge clock) disable iff (reset)
      advance && item_ff.kind != KIND_READ |-> result.read_data == '0)
      else $error("nonzero read data on a non-read transaction");

   a_count_held_when_off: assert property (@(posedge clock) disable iff (reset)
      !tstat.enable |-> tstat.count_zero)
      else $error("count moved while timer disabled");

   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("processed transaction produced no response");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_compare_capture_timer_core.sv
// testbench for compare_capture_timer_core: directed and random tick, register
// and TIN transactions checked against a cycle-free model of the timer
// depends on cct_pkg and the RTL of compare_capture_timer_core
module tb_compare_capture_timer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import cct_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 5;
   localparam int RANDOM_ITEMS   = 2000;
   localparam int HOLD_CYCLES    = 64;
   localparam int TAIL_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_REPORTS    = 10;
   localparam logic [2:0] SRC_SLOW = 3'd4;
   localparam logic [31:0] RUN_CTRL = (32'd1 << CTL_EN) | (32'(SRC_TICK) << CTL_SRC_LO)
      | (32'd1 << CTL_COMPEN) | (32'd1 << CTL_CAPTEN) | (32'(CAP_ANY) << CTL_MODE_LO);

   // mirrors the timer registers and holds the results still owed by the block
   class timer_scoreboard;
      logic [31:0] ctrl;
      logic [PRESCALE_W-1:0] prescale_val;
      logic [31:0] compare_val;
      logic [31:0] capture_val;
      logic [31:0] count_val;
      logic [1:0]  status;
      logic [DIV_W-1:0] prescale_cnt;
      result_type  owed_q[$];
      int unsigned failures;
      int unsigned checked;

      function new();
         clear_state(1'b0);
         failures = 0;
         checked  = 0;
      endfunction

      function void clear_state(logic keep_en);
         ctrl = '0;
         ctrl[CTL_EN] = keep_en;
         prescale_val = '0;
         compare_val  = '1;
         capture_val  = '0;
         count_val    = '0;
         status       = '0;
         prescale_cnt = '0;
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction

      function void note_item(item_type it);
         result_type  r;
         int unsigned p, div_val, next_cnt;
         logic [31:0] prev;
         logic [2:0]  src;
         logic [1:0]  mode;
         r = '0;
         unique case (it.kind)
            KIND_TICK: begin
               if (!ctrl[CTL_EN]) begin
                  count_val = '0;
               end else begin
                  src = ctrl[CTL_SRC_LO +: 3];
                  p = prescale_val + 1;
                  if (src == SRC_TICK) div_val = 2 * p;
                  else if (src == SRC_TICK_DIV) div_val = 8 * p;
                  else if (src >= SRC_SLOW) div_val = SLOW_CLOCK_DIVIDER;
                  else div_val = 0;
                  if (div_val != 0) begin
                     next_cnt = prescale_cnt + 1;
                     if (next_cnt < div_val) begin
                        prescale_cnt = next_cnt[DIV_W-1:0];
                     end else begin
                        prescale_cnt = '0;
                        prev = count_val;
                        count_val = prev + 1;
                        // a count that already passed compare wraps without an event
                        if (prev < compare_val && count_val == compare_val) begin
                           status[ST_COMP] = 1'b1;
                           if (!ctrl[CTL_FREERUN]) count_val = '0;
                           r.compare_hit = 1'b1;
                        end
                     end
                  end
               end
            end
            KIND_READ: begin
               unique case (it.reg_index)
                  REG_CTRL:     r.read_data = ctrl;
                  REG_PRESCALE: r.read_data = 32'(prescale_val);
                  REG_COMPARE:  r.read_data = compare_val;
                  REG_CAPTURE:  r.read_data = capture_val;
                  REG_COUNT:    r.read_data = count_val;
                  REG_STATUS:   r.read_data = 32'(status);
                  default:      r.read_data = '0;
               endcase
            end
            KIND_WRITE: begin
               unique case (it.reg_index)
                  REG_CTRL: begin
                     if (it.write_data[CTL_SOFTRST]) begin
                        clear_state(ctrl[CTL_EN]);
                     end else begin
                        ctrl = it.write_data;
                        if (!ctrl[CTL_EN]) count_val = '0;
                     end
                  end
                  REG_PRESCALE: prescale_val = it.write_data[PRESCALE_W-1:0];
                  REG_COMPARE:  compare_val = it.write_data;
                  REG_STATUS:   status = status & ~it.write_data[1:0];
                  default: ;
               endcase
            end
            default: begin
               mode = ctrl[CTL_MODE_LO +: 2];
               if (mode == CAP_ANY || (mode == CAP_RISE && it.tin_level)
                   || (mode == CAP_FALL && !it.tin_level)) begin
                  capture_val = ctrl[CTL_EN] ? count_val : '0;
                  status[ST_CAPT] = 1'b1;
               end
            end
         endcase
         r.irq_n = !((ctrl[CTL_COMPEN] && status[ST_COMP])
                     || (ctrl[CTL_CAPTEN] && status[ST_CAPT]));
         owed_q.push_back(r);
      endfunction

      function void check_result(logic [39:0] word);
         result_type want;
         checked++;
         if (owed_q.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("response %0d arrived with nothing outstanding: %h", checked, word);
            return;
         end
         want = owed_q.pop_front();
         if (word[31:0] !== want.read_data || word[32] !== want.irq_n
             || word[33] !== want.compare_hit) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display({"response %0d mismatch: read_data exp %h got %h, ",
                         "irq_n exp %b got %b, compare_hit exp %b got %b"},
                        checked, want.read_data, word[31:0], want.irq_n, word[32],
                        want.compare_hit, word[33]);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // reg_index[2:0], write_data[34:3], tin_level[35], zero
   logic [1:0]  req_tuser = '0;  // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;       // read_data[31:0], irq_n[32], compare_hit[33], zero

   logic        steady_phase = 1'b0;
   logic        hold_off_req = 1'b0;
   int          idle_cycles = 0;
   timer_scoreboard sb = new();

   compare_capture_timer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // sees every accepted transaction on both channels
   always @(posedge clock) begin
      item_type seen;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen.kind       = kind_type'(req_tuser);
            seen.reg_index  = req_tdata[2:0];
            seen.write_data = req_tdata[34:3];
            seen.tin_level  = req_tdata[35];
            sb.note_item(seen);
         end
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side: random stalls, always ready in the steady phase, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            hold_off_req = 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else if (steady_phase) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 13);
         end
      end
   end

   function automatic item_type make_item(kind_type kind, logic [2:0] idx,
                                          logic [31:0] data, logic level);
      item_type it;
      it.kind       = kind;
      it.reg_index  = idx;
      it.write_data = data;
      it.tin_level  = level;
      return it;
   endfunction

   function automatic item_type random_item();
      item_type    it;
      int unsigned pick;
      it = make_item(KIND_TICK, 3'($urandom_range(7)), $urandom, 1'($urandom_range(1)));
      pick = $urandom_range(99);
      if (pick >= 85) begin
         it.kind = KIND_TIN;
      end else if (pick >= 65) begin
         it.kind = KIND_WRITE;
         pick = $urandom_range(99);
         if (pick < 30) begin
            // mostly enabled and counting on the fast sources
            it.reg_index = REG_CTRL;
            it.write_data[CTL_EN] = ($urandom_range(99) < 85);
            it.write_data[CTL_SOFTRST] = ($urandom_range(99) < 3);
            pick = $urandom_range(9);
            it.write_data[CTL_SRC_LO +: 3] = (pick < 6) ? SRC_TICK
               : (pick < 8) ? SRC_TICK_DIV : 3'($urandom_range(7));
         end else if (pick < 45) begin
            it.reg_index = REG_PRESCALE;
            if ($urandom_range(99) < 70)
               it.write_data[PRESCALE_W-1:0] = PRESCALE_W'($urandom_range(3));
         end else if (pick < 65) begin
            it.reg_index = REG_COMPARE;
            pick = $urandom_range(9);
            if (pick < 6) it.write_data = $urandom_range(20, 1);
            else if (pick == 6) it.write_data = '0;
            else if (pick == 7) it.write_data = 32'hffff_ffff - $urandom_range(3);
         end else if (pick < 85) begin
            it.reg_index = REG_STATUS;
         end
         // otherwise the random index also reaches the ignored registers
      end else if (pick >= 45) begin
         it.kind = KIND_READ;
      end
      return it;
   endfunction

   task automatic send_item(input item_type it);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, it.tin_level, it.write_data, it.reg_index};
      req_tuser  <= it.kind;
      do @(posedge clock); while (!req_tready);
      // valid drops after about one item in seven, outside the steady phase
      if (!steady_phase && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(make_item(KIND_READ, REG_CTRL, '0, 1'b0));
      send_item(make_item(KIND_READ, REG_COMPARE, '1, 1'b1));
      send_item(make_item(KIND_TIN, REG_CTRL, '0, 1'b1));      // capture mode off
      send_item(make_item(KIND_TICK, REG_CTRL, '0, 1'b0));     // timer disabled
      send_item(make_item(KIND_WRITE, REG_PRESCALE, '1, 1'b0));
      send_item(make_item(KIND_READ, REG_PRESCALE, '0, 1'b0));
      send_item(make_item(KIND_WRITE, REG_PRESCALE, '0, 1'b0));
      send_item(make_item(KIND_WRITE, REG_COMPARE, 32'd3, 1'b0));
      send_item(make_item(KIND_WRITE, REG_CTRL, RUN_CTRL, 1'b0));
      // divide by two: the sixth tick reaches compare and restarts the count
      repeat (6) send_item(make_item(KIND_TICK, REG_CTRL, '0, 1'b0));
      send_item(make_item(KIND_READ, REG_STATUS, '0, 1'b0));
      send_item(make_item(KIND_TIN, REG_CTRL, '0, 1'b1));
      send_item(make_item(KIND_READ, REG_CAPTURE, '0, 1'b0));
      send_item(make_item(KIND_WRITE, REG_STATUS, '1, 1'b0));
      send_item(make_item(KIND_WRITE, REG_COUNT, '1, 1'b0));
      send_item(make_item(KIND_WRITE, 3'd7, '1, 1'b1));
      send_item(make_item(KIND_READ, 3'd6, '0, 1'b0));
      send_item(make_item(KIND_WRITE, REG_COMPARE, '0, 1'b0));  // compare of zero never hits
      send_item(make_item(KIND_WRITE, REG_CTRL, '1, 1'b0));     // soft reset keeps enable
      send_item(make_item(KIND_READ, REG_CTRL, '0, 1'b0));
      send_item(make_item(KIND_WRITE, REG_CTRL, 32'(CAP_RISE) << CTL_MODE_LO, 1'b0));
      send_item(make_item(KIND_TIN, REG_CTRL, '0, 1'b1));      // capture while disabled
      wait_for_drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 400) hold_off_req = 1'b1;
         if (n == 1000) wait_for_drain();
         steady_phase = (n >= 1300 && n < 1600);
         send_item(random_item());
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
